[rtl/pgpr_pkg.sv]
// Shared types, codes and constants of the pulse-gap packet receiver.
package pgpr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int CHANNELS_DEF     = 6;
  localparam int PACKET_BYTES_DEF = 16;

  // Fixed field widths of the channel beats.
  localparam int SAMPLE_W = 6;
  localparam int LIMIT_W  = 4;

  // The idle-window counter saturates here.
  localparam logic [LIMIT_W-1:0] IDLE_MAX = 4'd9;

  // Marker bit primed at the top of the shifter; a byte is complete when it
  // reaches the bottom.
  localparam logic [7:0] PRIME_MARK = 8'b1000_0000;
  localparam logic [7:0] LAST_MARK  = 8'b0000_0001;

  // Gap limits after reset.
  localparam logic [LIMIT_W-1:0] ONE_GAP_RESET  = 4'd1;
  localparam logic [LIMIT_W-1:0] DATA_GAP_RESET = 4'd3;
  localparam logic [LIMIT_W-1:0] SYNC_GAP_RESET = 4'd6;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_READ = 2'd1,
    OP_MARK = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_ONE_GAP  = 2'd0,
    CFG_DATA_GAP = 2'd1,
    CFG_SYNC_GAP = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] one_gap_limit;
    logic [LIMIT_W-1:0] data_gap_limit;
    logic [LIMIT_W-1:0] sync_gap_limit;
  } gap_cfg_t;

  // Per-lane command for the beat being accepted.
  typedef struct packed {
    logic tick;
    logic pulse;
    logic mark_read;
    logic rd_en;
  } lane_cmd_t;

endpackage

[rtl/pgpr_if.sv]
// Channel interfaces of the pulse-gap packet receiver: items, results, configuration.
interface pgpr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] pulse_samples;
  logic [2:0] channel;
  logic [3:0] byte_index;

  modport source (output valid, opcode, pulse_samples, channel, byte_index, input ready);
  modport sink   (input valid, opcode, pulse_samples, channel, byte_index, output ready);
endinterface

interface pgpr_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] ready_mask;
  logic       packet_ready;
  logic [4:0] packet_length;
  logic [7:0] packet_byte;

  modport source (output valid, ready_mask, packet_ready, packet_length, packet_byte,
                  input ready);
  modport sink   (input valid, ready_mask, packet_ready, packet_length, packet_byte,
                  output ready);
endinterface

interface pgpr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pgpr_lane.sv]
// One receive channel: gap classifier, byte shifter, flags and its packet memory.
module pgpr_lane #(
  parameter int PACKET_BYTES = pgpr_pkg::PACKET_BYTES_DEF,
  localparam int LEN_W = $clog2(PACKET_BYTES + 1),
  localparam int AW    = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  pgpr_pkg::gap_cfg_t  gap_cfg,
  input  pgpr_pkg::lane_cmd_t cmd,
  input  logic [3:0]          rd_index,
  output logic                ready,
  output logic                ready_next,
  output logic [LEN_W-1:0]    length,
  output logic [7:0]          rd_data
);
  import pgpr_pkg::*;

  logic [LIMIT_W-1:0] idle;
  logic [LIMIT_W-1:0] idle_next;
  logic [7:0]         shifter;
  logic [7:0]         shifter_next;
  logic [LEN_W-1:0]   length_next;
  logic [7:0]         shifted;
  logic               wr_en;
  logic               is_data;
  logic               is_sync;

  logic [7:0] store [PACKET_BYTES];

  assign is_data = (idle <= gap_cfg.data_gap_limit);
  assign is_sync = !is_data && (idle <= gap_cfg.sync_gap_limit);
  assign shifted = {(idle <= gap_cfg.one_gap_limit), shifter[7:1]};

  always_comb begin
    idle_next    = idle;
    shifter_next = shifter;
    length_next  = length;
    ready_next   = ready;
    wr_en        = 1'b0;
    if (cmd.tick) begin
      if (cmd.pulse) begin
        idle_next = '0;
        if (is_data) begin
          // Data bits are dropped while waiting for a sync.
          if (shifter != '0) begin
            if ((shifter & LAST_MARK) != '0) begin
              if (length < PACKET_BYTES) begin
                wr_en        = 1'b1;
                length_next  = LEN_W'(length + 1'b1);
                shifter_next = PRIME_MARK;
              end else begin
                shifter_next = '0;
                length_next  = '0;
              end
            end else begin
              shifter_next = shifted;
            end
          end
        end else if (is_sync) begin
          if (shifter == PRIME_MARK) begin
            // Closing sync on a byte boundary publishes a nonempty packet.
            if (length != '0) begin
              ready_next   = 1'b1;
              shifter_next = '0;
            end
          end else if (!ready) begin
            shifter_next = PRIME_MARK;
            length_next  = '0;
          end
        end else begin
          shifter_next = '0;
        end
      end else if (idle < IDLE_MAX) begin
        idle_next = idle + 1'b1;
      end
    end else if (cmd.mark_read) begin
      ready_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle    <= '0;
      shifter <= '0;
      length  <= '0;
      ready   <= 1'b0;
    end else begin
      idle    <= idle_next;
      shifter <= shifter_next;
      length  <= length_next;
      ready   <= ready_next;
    end
  end

  // The write uses the old length as its address; reads come only from
  // later beats, so they always see the committed byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[AW'(length)] <= shifted;
    end
    if (cmd.rd_en) begin
      rd_data <= store[AW'(rd_index)];
    end
  end

endmodule

[rtl/pulse_gap_packet_receiver_top.sv]
// Top level of the multichannel pulse-gap packet receiver.
//
//   Port    | Modport | Direction | Beat contents
//   --------+---------+-----------+------------------------------------------------
//   item    | sink    | in        | opcode, pulse_samples, channel, byte_index
//   result  | source  | out       | ready_mask, packet_ready, packet_length, packet_byte
//   cfg     | sink    | in        | index (gap limit register), data (4-bit limit)
//
// Every item beat yields exactly one result beat: the lane state and packet memories
// update at the accepting edge, the packet memory read data is registered in the next
// stage, and the output register follows. One item per cycle is sustained unless
// both stages are full and result.ready is low; the single write port of each lane's
// packet memory is enough since a tick stores at most one byte per channel.
// Reset (rst, synchronous, active high) clears all channel state, flags and
// the pipeline valids, and loads the default gap limits; packet bytes are not cleared.
// The item side stalls only when both the read stage and the output register hold a
// beat and result.ready is low. Configuration beats are always taken.
module pulse_gap_packet_receiver_top #(
  parameter int CHANNELS     = pgpr_pkg::CHANNELS_DEF,
  parameter int PACKET_BYTES = pgpr_pkg::PACKET_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  pgpr_item_if.sink     item,
  pgpr_result_if.source result,
  pgpr_cfg_if.sink      cfg
);
  import pgpr_pkg::*;

  localparam int LEN_W = $clog2(PACKET_BYTES + 1);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Gap limit registers.
  gap_cfg_t gap_cfg;

  // Lane connections.
  lane_cmd_t        lane_cmd  [CHANNELS];
  logic [7:0]       lane_rd   [CHANNELS];
  logic [LEN_W-1:0] lane_len  [CHANNELS];
  logic [CHANNELS-1:0] lane_rdy;
  logic [CHANNELS-1:0] lane_rdy_next;
  logic [SAMPLE_W-1:0] mask_next;

  // Decode of the beat on the item port.
  logic          accept;
  logic          op_tick;
  logic          op_read;
  logic          op_mark;
  logic          ch_ok;
  logic          idx_ok;
  logic [CH_W-1:0] ch_sel;

  // Read stage: the packet memories deliver their data here.
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_mask;
  logic                s1_rdy;
  logic [4:0]          s1_len;
  logic                s1_byte_ok;
  logic [CH_W-1:0]     s1_ch;
  logic                s1_adv;

  // Output register.
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_mask;
  logic                out_rdy;
  logic [4:0]          out_len;
  logic [7:0]          out_byte;

  assign accept  = item.valid && item.ready;
  assign op_tick = (item.opcode == OP_TICK);
  assign op_read = (item.opcode == OP_READ);
  assign op_mark = (item.opcode == OP_MARK);
  assign ch_ok   = (int'(item.channel) < CHANNELS);
  assign idx_ok  = (int'(item.byte_index) < PACKET_BYTES);
  assign ch_sel  = CH_W'(item.channel);

  // A new beat enters whenever the read stage is empty or moves on this cycle.
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign cfg.ready  = 1'b1;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_cfg.one_gap_limit  <= ONE_GAP_RESET;
      gap_cfg.data_gap_limit <= DATA_GAP_RESET;
      gap_cfg.sync_gap_limit <= SYNC_GAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_ONE_GAP:  gap_cfg.one_gap_limit  <= cfg.data;
        CFG_DATA_GAP: gap_cfg.data_gap_limit <= cfg.data;
        CFG_SYNC_GAP: gap_cfg.sync_gap_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // One lane per channel. Only the first SAMPLE_W channels see sample bits,
  // and only those appear in the ready mask.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic sample;

    if (c < SAMPLE_W) begin : g_sample
      assign sample = item.pulse_samples[c];
    end else begin : g_nosample
      assign sample = 1'b0;
    end

    always_comb begin
      lane_cmd[c].tick      = accept && op_tick;
      lane_cmd[c].pulse     = sample;
      lane_cmd[c].mark_read = accept && op_mark && ch_ok && (ch_sel == CH_W'(c));
      lane_cmd[c].rd_en     = accept && op_read;
    end

    pgpr_lane #(
      .PACKET_BYTES (PACKET_BYTES)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .gap_cfg    (gap_cfg),
      .cmd        (lane_cmd[c]),
      .rd_index   (item.byte_index),
      .ready      (lane_rdy[c]),
      .ready_next (lane_rdy_next[c]),
      .length     (lane_len[c]),
      .rd_data    (lane_rd[c])
    );
  end

  for (genvar m = 0; m < SAMPLE_W; m++) begin : g_mask
    if (m < CHANNELS) begin : g_used
      assign mask_next[m] = lane_rdy_next[m];
    end else begin : g_unused
      assign mask_next[m] = 1'b0;
    end
  end

  // Read stage. The ready flag and length are taken at acceptance, since a read
  // does not change them; the byte itself comes from the lane memory's read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mask    <= mask_next;
      s1_rdy     <= op_read && ch_ok && lane_rdy[ch_sel];
      s1_len     <= (op_read && ch_ok && lane_rdy[ch_sel]) ? 5'(lane_len[ch_sel]) : '0;
      s1_byte_ok <= op_read && ch_ok && idx_ok;
      s1_ch      <= ch_sel;
    end
  end

  // Output register, loaded from the read stage while the sink keeps up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mask <= s1_mask;
      out_rdy  <= s1_rdy;
      out_len  <= s1_len;
      out_byte <= s1_byte_ok ? lane_rd[s1_ch] : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.ready_mask    = out_mask;
  assign result.packet_ready  = out_rdy;
  assign result.packet_length = out_len;
  assign result.packet_byte   = out_byte;

  // A beat accepted always occupies the read stage on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat did not reach the read stage");

  // The item side only stalls when both stages are full and the sink is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("item port stalled without a full pipeline");

  // A beat held in the read stage keeps its captured flags until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv && !accept) |=> (s1_valid && $stable(s1_mask) && $stable(s1_len)))
    else $error("read stage beat changed while stalled");

  // A nonzero length is only ever reported for a ready packet.
  a_len_needs_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_len != '0)) |-> out_rdy)
    else $error("packet length reported without ready flag");

endmodule

[dv/pulse_gap_packet_receiver_checker.sv]
// Checker that predicts every result beat of the pulse-gap packet receiver and compares it.
module pulse_gap_packet_receiver_checker #(
  parameter int CHANNELS     = pgpr_pkg::CHANNELS_DEF,
  parameter int PACKET_BYTES = pgpr_pkg::PACKET_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  pgpr_item_if                                  item,
  pgpr_result_if                                result,
  pgpr_cfg_if                                   cfg,
  output int                                    fail_count,
  output int                                    pending,
  output logic [CHANNELS-1:0]                   flags_now,
  output logic [CHANNELS-1:0][PACKET_BYTES-1:0] bytes_written
);
  import pgpr_pkg::*;

  typedef struct packed {
    logic [5:0] ready_mask;
    logic       packet_ready;
    logic [4:0] packet_length;
    logic [7:0] packet_byte;
  } rx_result_t;

  logic [LIMIT_W-1:0]      one_lim;
  logic [LIMIT_W-1:0]      data_lim;
  logic [LIMIT_W-1:0]      sync_lim;
  logic [LIMIT_W-1:0]      idle_cnt [CHANNELS];
  logic [7:0]              shifter [CHANNELS];
  logic [7:0]              store [CHANNELS][PACKET_BYTES];
  int                      byte_count [CHANNELS];
  logic [CHANNELS-1:0]     ready_flags;
  logic [PACKET_BYTES-1:0] written [CHANNELS];
  rx_result_t              predicted_results [$];
  rx_result_t              oldest;
  int                      mismatches = 0;
  int                      waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;
  assign flags_now  = ready_flags;
  for (genvar g = 0; g < CHANNELS; g++) begin : g_written
    assign bytes_written[g] = written[g];
  end

  // A pulse ends the gap on channel c; the gap length decides what it means.
  function automatic void take_pulse(int c);
    logic [LIMIT_W-1:0] gap;
    logic [7:0]         sh;
    logic [7:0]         next_sh;
    gap = idle_cnt[c];
    sh  = shifter[c];
    if (gap <= data_lim) begin
      if (sh != 8'd0) begin
        next_sh = (sh >> 1) | ((gap <= one_lim) ? PRIME_MARK : 8'd0);
        if (|(sh & LAST_MARK)) begin
          if (byte_count[c] < PACKET_BYTES) begin
            store[c][byte_count[c]]   = next_sh;
            written[c][byte_count[c]] = 1'b1;
            byte_count[c]++;
            shifter[c] = PRIME_MARK;
          end else begin
            shifter[c]    = 8'd0;
            byte_count[c] = 0;
          end
        end else begin
          shifter[c] = next_sh;
        end
      end
    end else if (gap <= sync_lim) begin
      if (sh == PRIME_MARK) begin
        if (byte_count[c] != 0) begin
          ready_flags[c] = 1'b1;
          shifter[c]     = 8'd0;
        end
      end else if (!ready_flags[c]) begin
        shifter[c]    = PRIME_MARK;
        byte_count[c] = 0;
      end
    end else begin
      shifter[c] = 8'd0;
    end
    idle_cnt[c] = '0;
  endfunction

  function automatic rx_result_t predict_result(logic [1:0] op, logic [5:0] samples,
                                                logic [2:0] ch, logic [3:0] idx);
    rx_result_t r;
    r = '0;
    if (op == OP_TICK) begin
      for (int c = 0; c < CHANNELS && c < SAMPLE_W; c++) begin
        if (samples[c]) take_pulse(c);
        else if (idle_cnt[c] < IDLE_MAX) idle_cnt[c] = idle_cnt[c] + 1'b1;
      end
    end else if (op == OP_READ) begin
      if (ch < CHANNELS) begin
        r.packet_ready  = ready_flags[ch];
        r.packet_length = ready_flags[ch] ? 5'(byte_count[ch]) : 5'd0;
        if (idx < PACKET_BYTES) r.packet_byte = store[ch][idx];
      end
    end else if (op == OP_MARK) begin
      if (ch < CHANNELS) ready_flags[ch] = 1'b0;
    end
    r.ready_mask = 6'(ready_flags);
    return r;
  endfunction

  function automatic void check_field(string field, int expected, int actual);
    if (expected != actual) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      one_lim  = ONE_GAP_RESET;
      data_lim = DATA_GAP_RESET;
      sync_lim = SYNC_GAP_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        idle_cnt[c]   = '0;
        shifter[c]    = 8'd0;
        byte_count[c] = 0;
        written[c]    = '0;
      end
      ready_flags = '0;
      predicted_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, actual mask %0d ready %0d len %0d byte %0d",
                   $time, result.ready_mask, result.packet_ready, result.packet_length,
                   result.packet_byte);
        end else begin
          oldest = predicted_results.pop_front();
          check_field("ready_mask", oldest.ready_mask, result.ready_mask);
          check_field("packet_ready", oldest.packet_ready, result.packet_ready);
          check_field("packet_length", oldest.packet_length, result.packet_length);
          check_field("packet_byte", oldest.packet_byte, result.packet_byte);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_ONE_GAP:  one_lim  = cfg.data;
          CFG_DATA_GAP: data_lim = cfg.data;
          CFG_SYNC_GAP: sync_lim = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        predicted_results.push_back(predict_result(item.opcode, item.pulse_samples,
                                                   item.channel, item.byte_index));
      end
    end
    waiting = predicted_results.size();
  end

endmodule

[dv/pulse_gap_packet_receiver_top_tb.sv]
// Top of the pulse-gap packet receiver testbench: clock, reset, stimulus and verdict.
module pulse_gap_packet_receiver_top_tb;
  import pgpr_pkg::*;

  localparam int CHANNELS     = CHANNELS_DEF;
  localparam int PACKET_BYTES = PACKET_BYTES_DEF;

  // Opcode 3 has no meaning; the block must leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 225;
  localparam int PHASES       = 8;
  // Gaps above the saturation value all look the same to the block.
  localparam int MAX_GAP      = 10;

  // Where each channel stands in the packet it is currently sending.
  typedef enum {PLAN_OPEN, PLAN_DATA, PLAN_CLOSE} plan_stage_t;
  // What the next pulse of a channel is meant to be read as.
  typedef enum {GAP_ONE, GAP_ZERO, GAP_SYNC, GAP_ABORT} gap_class_t;

  logic clk;
  logic rst;

  pgpr_item_if   item_ch ();
  pgpr_result_if result_ch ();
  pgpr_cfg_if    cfg_ch ();

  int                                    fail_count;
  int                                    pending;
  logic [CHANNELS-1:0]                   flags_now;
  logic [CHANNELS-1:0][PACKET_BYTES-1:0] written;

  pulse_gap_packet_receiver_top #(
    .CHANNELS    (CHANNELS),
    .PACKET_BYTES(PACKET_BYTES)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  pulse_gap_packet_receiver_checker #(
    .CHANNELS    (CHANNELS),
    .PACKET_BYTES(PACKET_BYTES)
  ) packet_check (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .flags_now    (flags_now),
    .bytes_written(written)
  );

  // Idling controls, shared between the sender and the receiver processes.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;
  int cycle_count;

  // The gap limits the block currently holds, used to aim the generated gaps.
  int one_lim;
  int data_lim;
  int sync_lim;

  // Per-channel packet plans: idle ticks left before the next pulse, data bits
  // left in the packet, the stage, and whether this packet carries noise.
  int          gap_left [CHANNELS];
  int          bits_left [CHANNELS];
  plan_stage_t stage [CHANNELS];
  bit          dirty [CHANNELS];

  logic [1:0] rand_op;
  logic [5:0] rand_samples;
  logic [2:0] rand_ch;
  logic [3:0] rand_idx;
  int         p_one, p_data, p_sync;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a run that has not ended by the cycle limit has hung somewhere.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pulse_gap_packet_receiver_top_tb failed");
    $finish;
  end

  // Receiver side. It stalls at random by the current percentage, and when
  // asked it holds off for a long stretch so the pipeline fills and the item
  // channel backs up while the sender keeps offering beats.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Picks a gap in [lo, hi]; an empty range under the current limits falls
  // back to any gap at all, which simply acts as noise.
  function automatic int pick_in(int lo, int hi);
    if (lo > hi) return $urandom_range(MAX_GAP);
    return $urandom_range(hi, lo);
  endfunction

  function automatic int gap_for(gap_class_t k);
    case (k)
      GAP_ONE:  return pick_in(0, (one_lim < data_lim) ? one_lim : data_lim);
      GAP_ZERO: return pick_in(one_lim + 1, data_lim);
      GAP_SYNC: return pick_in(data_lim + 1, sync_lim);
      default:  return pick_in(((data_lim > sync_lim) ? data_lim : sync_lim) + 1, MAX_GAP);
    endcase
  endfunction

  // Advances the packet plan of channel c and returns the idle ticks that
  // precede its next pulse. Most packets are well formed: an opening sync,
  // whole bytes of random bits, a closing sync. Some are sprinkled with
  // random gaps and aborts, and now and then the opening sync is doubled,
  // which gives a sync on a byte boundary with nothing stored.
  function automatic int plan_next_gap(int c);
    int r;
    int n_bytes;
    if (dirty[c] && $urandom_range(99) < 6) begin
      if ($urandom_range(1)) return $urandom_range(MAX_GAP);
      return gap_for(GAP_ABORT);
    end
    case (stage[c])
      PLAN_OPEN: begin
        if ($urandom_range(99) < 10) return gap_for(GAP_SYNC);
        // Mostly short packets; a few fill the store or overflow it.
        r = $urandom_range(99);
        if (r < 75) n_bytes = $urandom_range(3, 1);
        else if (r < 92) n_bytes = $urandom_range(8, 4);
        else n_bytes = $urandom_range(PACKET_BYTES + 1, PACKET_BYTES - 1);
        bits_left[c] = 8 * n_bytes;
        dirty[c]     = ($urandom_range(99) < 20);
        stage[c]     = PLAN_DATA;
        return gap_for(GAP_SYNC);
      end
      PLAN_DATA: begin
        bits_left[c]--;
        if (bits_left[c] == 0) stage[c] = PLAN_CLOSE;
        if ($urandom_range(1)) return gap_for(GAP_ONE);
        return gap_for(GAP_ZERO);
      end
      default: begin
        stage[c] = PLAN_OPEN;
        return gap_for(GAP_SYNC);
      end
    endcase
  endfunction

  // Returns the position of a randomly chosen set bit, or 0 if none is set.
  function automatic int random_set_bit(longint unsigned bits);
    int k;
    if (bits == 0) return 0;
    k = $urandom_range($countones(bits) - 1);
    for (int i = 0; i < 64; i++) begin
      if (bits[i]) begin
        if (k == 0) return i;
        k--;
      end
    end
    return 0;
  endfunction

  // Builds one random beat. Ticks follow the packet plans. Reads only touch
  // store entries that have been written, favoring channels with a packet
  // ready; channels with nothing stored are read only out of range. Marks
  // mostly release a ready channel so that new packets can be taken.
  function automatic void build_random_item(output logic [1:0] op, output logic [5:0] samples,
                                            output logic [2:0] ch, output logic [3:0] idx);
    int                  r;
    logic [CHANNELS-1:0] has_bytes;
    samples = '0;
    ch      = 3'($urandom_range(7));
    idx     = 4'($urandom_range(15));
    r       = $urandom_range(99);
    if (r < 74) begin
      op = OP_TICK;
      for (int c = 0; c < CHANNELS; c++) begin
        if (gap_left[c] == 0) begin
          samples[c]  = 1'b1;
          gap_left[c] = plan_next_gap(c);
        end else begin
          gap_left[c]--;
        end
      end
    end else if (r < 87) begin
      op = OP_READ;
      for (int c = 0; c < CHANNELS; c++) has_bytes[c] = |written[c];
      if (flags_now != '0 && $urandom_range(99) < 60) ch = 3'(random_set_bit(flags_now));
      else if (has_bytes != '0 && $urandom_range(99) < 85) ch = 3'(random_set_bit(has_bytes));
      else ch = 3'($urandom_range(7, CHANNELS));
      if (ch < CHANNELS) idx = 4'(random_set_bit(written[ch]));
    end else if (r < 97) begin
      op = OP_MARK;
      if (flags_now != '0 && $urandom_range(99) < 70) ch = 3'(random_set_bit(flags_now));
    end else begin
      op = OP_UNUSED;
    end
  endfunction

  // Waits for the next falling edge and then idles the sender at random.
  task automatic wait_sender_slot();
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Puts one beat on the item channel and waits until the block takes it.
  task automatic offer_item(input logic [1:0] op, input logic [5:0] samples,
                            input logic [2:0] ch, input logic [3:0] idx);
    item_ch.valid         <= 1'b1;
    item_ch.opcode        <= op;
    item_ch.pulse_samples <= samples;
    item_ch.channel       <= ch;
    item_ch.byte_index    <= idx;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic directed_item(input logic [1:0] op, input logic [5:0] samples,
                               input logic [2:0] ch, input logic [3:0] idx);
    wait_sender_slot();
    offer_item(op, samples, ch, idx);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_limit(input cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= LIMIT_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.opcode        = OP_TICK;
    item_ch.pulse_samples = '0;
    item_ch.channel       = '0;
    item_ch.byte_index    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_ONE_GAP;
    cfg_ch.data           = '0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_request          = 1'b0;
    hold_left             = 0;
    one_lim               = ONE_GAP_RESET;
    data_lim              = DATA_GAP_RESET;
    sync_lim              = SYNC_GAP_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, under the reset limits (one up to 1, data up to 3,
    // sync up to 6). Nothing is stored yet, so reads go out of range only.
    directed_item(OP_UNUSED, 6'h3F, 3'd7, 4'd15);
    directed_item(OP_UNUSED, 6'h00, 3'd0, 4'd0);
    directed_item(OP_READ, 6'h00, 3'd6, 4'd0);
    directed_item(OP_READ, 6'h3F, 3'd7, 4'd15);
    directed_item(OP_MARK, 6'h00, 3'd7, 4'd0);
    directed_item(OP_MARK, 6'h00, 3'd0, 4'd0);
    // A data bit while still waiting for a sync is dropped.
    directed_item(OP_TICK, 6'h3F, 3'd0, 4'd0);
    // Gap of four opens a packet on every channel.
    repeat (4) directed_item(OP_TICK, 6'h00, 3'd0, 4'd0);
    directed_item(OP_TICK, 6'h3F, 3'd0, 4'd0);
    // A second sync straight away sits on a byte boundary with nothing
    // stored, so it must change nothing.
    repeat (4) directed_item(OP_TICK, 6'h00, 3'd0, 4'd0);
    directed_item(OP_TICK, 6'h3F, 3'd0, 4'd0);
    // A gap of seven is too long and aborts reception.
    repeat (7) directed_item(OP_TICK, 6'h00, 3'd0, 4'd0);
    directed_item(OP_TICK, 6'h3F, 3'd0, 4'd0);

    // Every channel has just pulsed, so the plans start from a zero count.
    for (int c = 0; c < CHANNELS; c++) begin
      stage[c]    = PLAN_OPEN;
      bits_left[c] = 0;
      dirty[c]    = 1'b0;
      gap_left[c] = plan_next_gap(c);
    end

    // Random phases. Each phase runs under its own gap limits, extremes
    // among them, and its own idling pattern. Limits change only once the
    // block has handed back every result.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin p_one = 1; p_data = 3; p_sync = 6; send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin p_one = 0; p_data = 2; p_sync = 5; send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin p_one = 2; p_data = 5; p_sync = 8; send_idle_pct = 0;  recv_stall_pct = 80; end
        3: begin p_one = 0; p_data = 0; p_sync = 0; send_idle_pct = 13; recv_stall_pct = 13; end
        4: begin p_one = 8; p_data = 8; p_sync = 8; send_idle_pct = 0;  recv_stall_pct = 0;  end
        // Every data bit is a one when the one limit reaches the data limit.
        5: begin p_one = 5; p_data = 3; p_sync = 7; send_idle_pct = 13; recv_stall_pct = 13; end
        // No gap can be a sync when the sync limit is not above the data limit.
        6: begin p_one = 1; p_data = 6; p_sync = 4; send_idle_pct = 80; recv_stall_pct = 0;  end
        default: begin
          p_one = 1; p_data = 3; p_sync = 6; send_idle_pct = 0; recv_stall_pct = 80;
        end
      endcase
      // The first phase keeps the limits loaded by reset.
      if (phase > 0) begin
        write_limit(CFG_ONE_GAP, p_one);
        write_limit(CFG_DATA_GAP, p_data);
        write_limit(CFG_SYNC_GAP, p_sync);
        one_lim  = p_one;
        data_lim = p_data;
        sync_lim = p_sync;
      end
      // The first phase opens with a long receiver hold-off.
      if (phase == 0) hold_request = 1'b1;
      repeat (PHASE_ITEMS) begin
        wait_sender_slot();
        build_random_item(rand_op, rand_samples, rand_ch, rand_idx);
        offer_item(rand_op, rand_samples, rand_ch, rand_idx);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("pulse_gap_packet_receiver_top_tb passed");
    end else begin
      $display("pulse_gap_packet_receiver_top_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pgpr_pkg.sv
rtl/pgpr_if.sv
rtl/pgpr_lane.sv
rtl/pulse_gap_packet_receiver_top.sv
dv/pulse_gap_packet_receiver_checker.sv
dv/pulse_gap_packet_receiver_top_tb.sv
